FILE: hdl/io_port_bitmap_range_update_defines.svh
// assertion macros for the port bitmap block
`ifndef IO_PORT_BITMAP_RANGE_UPDATE_DEFINES_SVH
`define IO_PORT_BITMAP_RANGE_UPDATE_DEFINES_SVH

// clocked assertion, switched off while reset is held
`define IOPBR_ASSERT_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");

// clocked assertion, checked during reset as well
`define IOPBR_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("%m: assertion failed");

`endif

FILE: hdl/iopbr_pkg.sv
// shared types and constants of the port bitmap block
`default_nettype none
package iopbr_pkg;

    // field widths
    localparam int PORT_W      = 16;
    localparam int LG_W        = 5;
    localparam int IDX_W       = 11;
    localparam int DATA_W      = 32;
    localparam int KIND_W      = 2;

    // range size exponent above this reaches the last port anyway
    localparam int LG_CLAMP    = 17;
    // fixed point shift of the word size reciprocal
    localparam int RECIP_SHIFT = 22;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SET   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

    // commands from controller to datapath
    typedef struct packed {
        logic clr_wr;
        logic load;
        logic mul;
        logic quo;
        logic fix;
        logic walk_rd;
        logic walk_wr;
        logic final_rd;
        logic out_load;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic clr_last;
        logic upd;
        logic more;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

FILE: hdl/iopbr_ram.sv
// generic single write, single read RAM with registered read
`default_nettype none
module iopbr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

FILE: hdl/iopbr_ctrl.sv
// controller state machine of the port bitmap block
`default_nettype none
module iopbr_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire iopbr_pkg::t_sts i_sts,
    output iopbr_pkg::t_cmd    o_cmd
);
    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_MUL  = 4'd2;
    localparam logic [3:0] S_QUO  = 4'd3;
    localparam logic [3:0] S_FIX  = 4'd4;
    localparam logic [3:0] S_WRD  = 4'd5;
    localparam logic [3:0] S_WWR  = 4'd6;
    localparam logic [3:0] S_RRD  = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_CLR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_QUO;
            end
            S_QUO: begin
                o_cmd.quo = 1'b1;
                n_state   = S_FIX;
            end
            S_FIX: begin
                o_cmd.fix = 1'b1;
                n_state   = i_sts.upd ? S_WRD : S_RRD;
            end
            S_WRD: begin
                o_cmd.walk_rd = 1'b1;
                n_state       = S_WWR;
            end
            S_WWR: begin
                o_cmd.walk_wr = 1'b1;
                n_state       = i_sts.more ? S_WRD : S_RRD;
            end
            S_RRD: begin
                o_cmd.final_rd = 1'b1;
                n_state        = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end
endmodule
`default_nettype wire

FILE: hdl/iopbr_dp.sv
// datapath of the port bitmap block: word index, range walk, bitmap RAM, result register
`default_nettype none
module iopbr_dp #(
    parameter int PORT_COUNT = 65536,
    parameter int WORD_BITS  = 32
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire iopbr_pkg::t_cmd                      i_cmd,
    output iopbr_pkg::t_sts                           o_sts,
    input  wire logic [iopbr_pkg::KIND_W-1:0]         i_kind,
    input  wire logic [iopbr_pkg::PORT_W-1:0]         i_port,
    input  wire logic [iopbr_pkg::LG_W-1:0]           i_log2_size,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_stall,
    output logic      [iopbr_pkg::IDX_W-1:0]          o_word_index,
    output logic      [iopbr_pkg::DATA_W-1:0]         o_word_data
);
    localparam int WORD_COUNT = (PORT_COUNT + WORD_BITS - 1) / WORD_BITS;
    localparam int AW         = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int RECIP      = (1 << iopbr_pkg::RECIP_SHIFT) / WORD_BITS;
    localparam int RW         = $clog2(RECIP + 1);
    localparam int PW         = iopbr_pkg::PORT_W + RW;
    localparam int CW         = $clog2(WORD_BITS + 1);
    localparam int PORT_W     = iopbr_pkg::PORT_W;
    localparam int DATA_W     = iopbr_pkg::DATA_W;
    localparam int IDX_W      = iopbr_pkg::IDX_W;

    // latched item
    logic [iopbr_pkg::KIND_W-1:0] r_kind;
    logic [PORT_W-1:0]            r_port;
    logic [iopbr_pkg::LG_W-1:0]   r_lg;

    // index arithmetic
    logic [PW-1:0]     r_prod;
    logic [PORT_W-1:0] r_q;
    logic [PORT_W:0]   r_qwb;
    logic [PORT_W-1:0] r_widx;
    logic [PORT_W-1:0] r_w;
    logic [PORT_W+1:0] r_base;
    logic [PORT_W+1:0] r_end;
    logic              r_vport;

    // clearing pass and result register
    logic [AW-1:0]     r_clr;
    logic              r_ov;
    logic [IDX_W-1:0]  r_oidx;
    logic [DATA_W-1:0] r_odata;

    logic [PORT_W:0]          rem;
    logic                     adj;
    logic [iopbr_pkg::LG_W-1:0] lgc;
    logic [PORT_W+1:0]        span;
    logic [PORT_W+1:0]        sum;
    logic [PORT_W+1:0]        n_end;
    logic [CW-1:0]            lo;
    logic [CW-1:0]            hi;
    logic [WORD_BITS-1:0]     mask;
    logic [WORD_BITS-1:0]     walk_wdata;
    logic [WORD_BITS-1:0]     rdata;
    logic [WORD_BITS+DATA_W-1:0] pad_data;
    logic [WORD_BITS+DATA_W-1:0] pad_ones;

    logic                     ram_we;
    logic [AW-1:0]            ram_waddr;
    logic [WORD_BITS-1:0]     ram_wdata;
    logic                     ram_re;
    logic [AW-1:0]            ram_raddr;

    // quotient correction and range end
    always_comb begin
        rem   = {1'b0, r_port} - r_qwb;
        adj   = (rem >= (PORT_W+1)'(WORD_BITS));
        lgc   = (r_lg > iopbr_pkg::LG_W'(iopbr_pkg::LG_CLAMP))
                ? iopbr_pkg::LG_W'(iopbr_pkg::LG_CLAMP) : r_lg;
        span  = (PORT_W+2)'(1) << lgc;
        sum   = (PORT_W+2)'(r_port) + span;
        n_end = (sum > (PORT_W+2)'(PORT_COUNT)) ? (PORT_W+2)'(PORT_COUNT) : sum;
    end

    // bit mask of the current word within the range
    always_comb begin
        lo = ((PORT_W+2)'(r_port) > r_base) ? CW'((PORT_W+2)'(r_port) - r_base) : '0;
        hi = ((r_end - r_base) >= (PORT_W+2)'(WORD_BITS))
             ? CW'(WORD_BITS) : CW'(r_end - r_base);
        for (int i = 0; i < WORD_BITS; i++) begin
            mask[i] = (CW'(i) >= lo) && (CW'(i) < hi);
        end
        walk_wdata = (r_kind == iopbr_pkg::KIND_CLEAR) ? (rdata & ~mask) : (rdata | mask);
    end

    // RAM port selection
    always_comb begin
        ram_we    = i_cmd.clr_wr | i_cmd.walk_wr;
        ram_waddr = i_cmd.clr_wr ? r_clr : r_w[AW-1:0];
        ram_wdata = i_cmd.clr_wr ? {WORD_BITS{1'b1}} : walk_wdata;
        ram_re    = i_cmd.walk_rd | (i_cmd.final_rd & r_vport);
        ram_raddr = i_cmd.walk_rd ? r_w[AW-1:0] : r_widx[AW-1:0];
    end

    iopbr_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORD_COUNT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (rdata)
    );

    // item registers and index steps
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind  <= i_kind;
            r_port  <= i_port;
            r_lg    <= i_log2_size;
        end
        if (i_cmd.mul) begin
            r_prod  <= PW'(r_port) * PW'(RECIP);
            r_vport <= ({1'b0, r_port} < (PORT_W+1)'(PORT_COUNT));
            r_end   <= n_end;
        end
        if (i_cmd.quo) begin
            r_q     <= PORT_W'(r_prod >> iopbr_pkg::RECIP_SHIFT);
            r_qwb   <= (PORT_W+1)'(PW'(r_prod >> iopbr_pkg::RECIP_SHIFT) * PW'(WORD_BITS));
        end
        if (i_cmd.fix) begin
            r_widx  <= adj ? (r_q + PORT_W'(1)) : r_q;
            r_w     <= adj ? (r_q + PORT_W'(1)) : r_q;
            r_base  <= (PORT_W+2)'(r_qwb) + (adj ? (PORT_W+2)'(WORD_BITS) : '0);
        end
        if (i_cmd.walk_wr) begin
            r_w     <= r_w + PORT_W'(1);
            r_base  <= r_base + (PORT_W+2)'(WORD_BITS);
        end
    end

    // clearing pass counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr <= r_clr + AW'(1);
        end
    end

    // result word, low bits of the bitmap word or all ones for a port out of range
    always_comb begin
        pad_data = {{DATA_W{1'b0}}, rdata};
        pad_ones = {{DATA_W{1'b0}}, {WORD_BITS{1'b1}}};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_oidx  <= r_widx[IDX_W-1:0];
            r_odata <= r_vport ? pad_data[DATA_W-1:0] : pad_ones[DATA_W-1:0];
        end
    end

    // result beat valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ov <= 1'b1;
        end else if (!i_out_stall) begin
            r_ov <= 1'b0;
        end
    end

    // status
    always_comb begin
        o_sts.clr_last = (r_clr == AW'(WORD_COUNT - 1));
        o_sts.upd      = r_vport && ((r_kind == iopbr_pkg::KIND_CLEAR) ||
                                     (r_kind == iopbr_pkg::KIND_SET));
        o_sts.more     = ((r_base + (PORT_W+2)'(WORD_BITS)) < r_end);
        o_sts.out_free = !r_ov || !i_out_stall;
    end

    assign o_out_valid  = r_ov;
    assign o_word_index = r_oidx;
    assign o_word_data  = r_odata;
endmodule
`default_nettype wire

FILE: hdl/io_port_bitmap_range_update.sv
// I/O port permission bitmap: range grant, range revoke and word read.
// Each item: the input beat is latched, the word index is computed in the multiply, quotient
// and correction states, then each bitmap word the range touches (none for reads and for ports
// out of range) is one RAM read and one write. The next item is taken only after the result
// is loaded into the result register. Reset: a clearing pass writes all ones to every word,
// with the input stalled until it ends.
`default_nettype none
module io_port_bitmap_range_update #(
    parameter int PORT_COUNT = 65536,
    parameter int WORD_BITS  = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic [iopbr_pkg::KIND_W-1:0] i_kind,
    input  wire logic [iopbr_pkg::PORT_W-1:0] i_port,
    input  wire logic [iopbr_pkg::LG_W-1:0]   i_log2_size,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic      [iopbr_pkg::IDX_W-1:0]  o_word_index,
    output logic      [iopbr_pkg::DATA_W-1:0] o_word_data
);
    iopbr_pkg::t_cmd cmd;
    iopbr_pkg::t_sts sts;

    // sequencing
    iopbr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // arithmetic, bitmap store and result register
    iopbr_dp #(
        .PORT_COUNT (PORT_COUNT),
        .WORD_BITS  (WORD_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_kind       (i_kind),
        .i_port       (i_port),
        .i_log2_size  (i_log2_size),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_word_index (o_word_index),
        .o_word_data  (o_word_data)
    );
endmodule
`default_nettype wire

FILE: hdl/iopbr_checker.sv
// port level checks of the port bitmap block and their bind
`default_nettype none
`include "io_port_bitmap_range_update_defines.svh"
module iopbr_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_in_valid,
    input wire logic                         o_in_stall,
    input wire logic [iopbr_pkg::KIND_W-1:0] i_kind,
    input wire logic [iopbr_pkg::PORT_W-1:0] i_port,
    input wire logic [iopbr_pkg::LG_W-1:0]   i_log2_size,
    input wire logic                         o_out_valid,
    input wire logic                         i_out_stall,
    input wire logic [iopbr_pkg::IDX_W-1:0]  o_word_index,
    input wire logic [iopbr_pkg::DATA_W-1:0] o_word_data
);
    logic in_beat;
    logic item_bits;

    assign in_beat   = i_in_valid && !o_in_stall;
    assign item_bits = ^{i_kind, i_port, i_log2_size};

    // a stalled result beat holds its payload
    `IOPBR_ASSERT_RST(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_word_index) && $stable(o_word_data))

    // one item at a time: input stalls right after a beat
    `IOPBR_ASSERT_RST(a_one_item, i_clk, i_rst_n, in_beat |=> o_in_stall)

    // no result beat appears in the cycle after an input beat
    `IOPBR_ASSERT_RST(a_no_instant, i_clk, i_rst_n, in_beat && (item_bits || !item_bits) |=> !$rose(o_out_valid))

    // reset empties the result register
    `IOPBR_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !o_out_valid)
endmodule

bind io_port_bitmap_range_update iopbr_checker u_chk (.*);
`default_nettype wire
